// ===== hdl/rbs_pkg.sv =====
// ============================================================================
// rbs_pkg
// Shared widths, constants and types of the ray / box slab test pipeline.
// ============================================================================
package rbs_pkg;

    // Coordinate width (signed Q16.16)
    localparam int unsigned COORD_W = 32;
    // Fraction bits of the coordinate format
    localparam int unsigned FRAC_W = 16;
    // Number of axes and divider lanes (low and high corner per axis)
    localparam int unsigned AXES  = 3;
    localparam int unsigned LANES = 2 * AXES;
    // Magnitude of (corner - origin), then scaled by 2^FRAC_W
    localparam int unsigned DIFF_W = COORD_W + 1;
    localparam int unsigned NUM_W  = DIFF_W + FRAC_W;
    // Divisor magnitude and partial remainder width
    localparam int unsigned DEN_W = COORD_W;
    // One quotient bit per divider stage
    localparam int unsigned DIV_STAGES = NUM_W;
    // Signed slab distance width, with room for the infinity markers
    localparam int unsigned T_W = NUM_W + 3;

    typedef logic signed [T_W-1:0] t_dist;

    localparam t_dist POS_INF = t_dist'(64'sd1 <<< (T_W - 2));
    localparam t_dist NEG_INF = -POS_INF;
    localparam t_dist SAT_HI  = t_dist'(64'sd2147483647);
    localparam t_dist SAT_LO  = t_dist'(-64'sd2147483648);

    // Control that travels beside the divider lanes
    typedef struct packed {
        logic            valid;
        logic [AXES-1:0] zero;
        logic [AXES-1:0] in_slab;
    } t_side;

endpackage

// ===== hdl/rbs_div.sv =====
// ============================================================================
// rbs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ============================================================================
module rbs_div
    import rbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_neg,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_neg
);

    logic [DEN_W-1:0] r_rem [DIV_STAGES];
    logic [NUM_W-1:0] r_dvd [DIV_STAGES];
    logic [DEN_W-1:0] r_den [DIV_STAGES];
    logic             r_neg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] dvd_in;
        logic [DEN_W-1:0] den_in;
        logic             neg_in;
        logic [DEN_W:0]   tmp;
        logic [DEN_W:0]   sub;
        logic             ge;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_dvd;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign dvd_in = i_num;
            assign den_in = i_den;
            assign neg_in = i_neg;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign dvd_in = r_dvd[s-1];
            assign den_in = r_den[s-1];
            assign neg_in = r_neg[s-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        always_comb begin
            tmp   = {rem_in, dvd_in[NUM_W-1]};
            sub   = tmp - {1'b0, den_in};
            ge    = (tmp >= {1'b0, den_in});
            n_rem = ge ? sub[DEN_W-1:0] : tmp[DEN_W-1:0];
            n_dvd = {dvd_in[NUM_W-2:0], ge};
        end

        // Advance the stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_dvd[s] <= n_dvd;
                r_den[s] <= den_in;
                r_neg[s] <= neg_in;
            end
        end
    end

    assign o_quo = r_dvd[DIV_STAGES-1];
    assign o_neg = r_neg[DIV_STAGES-1];

endmodule

// ===== hdl/rbs_reduce.sv =====
// ============================================================================
// rbs_reduce
// Signs the quotients, forms the slabs, reduces to near / far, tests the hit and saturates.
// ============================================================================
module rbs_reduce
    import rbs_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  t_side                       i_side,
    input  logic [LANES-1:0][NUM_W-1:0] i_quo,
    input  logic [LANES-1:0]            i_neg,
    output logic                        o_valid,
    output logic [COORD_W-1:0]          o_near,
    output logic [COORD_W-1:0]          o_far,
    output logic                        o_hit
);

    t_side r_s1_side, r_s2_side, r_s3_side;
    t_dist r_s1_q  [LANES];
    t_dist r_s2_lo [AXES];
    t_dist r_s2_hi [AXES];
    t_dist r_s3_near, r_s3_far;
    logic  r_s4_valid;
    logic [COORD_W-1:0] r_s4_near, r_s4_far;
    logic  r_s4_hit;

    t_dist n_s1_q  [LANES];
    t_dist n_s2_lo [AXES];
    t_dist n_s2_hi [AXES];
    t_dist n_s3_near, n_s3_far;
    t_dist ext;
    logic [COORD_W-1:0] n_s4_near, n_s4_far;
    logic  n_s4_hit;

    // Apply the quotient sign
    always_comb begin
        ext = '0;
        for (int k = 0; k < LANES; k++) begin
            ext       = t_dist'({{(T_W-NUM_W){1'b0}}, i_quo[k]});
            n_s1_q[k] = i_neg[k] ? -ext : ext;
        end
    end

    // Order each slab; a zero direction gives an open or an empty slab
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (r_s1_side.zero[a]) begin
                n_s2_lo[a] = r_s1_side.in_slab[a] ? NEG_INF : POS_INF;
                n_s2_hi[a] = r_s1_side.in_slab[a] ? POS_INF : NEG_INF;
            end else if (r_s1_q[a] < r_s1_q[a+AXES]) begin
                n_s2_lo[a] = r_s1_q[a];
                n_s2_hi[a] = r_s1_q[a+AXES];
            end else begin
                n_s2_lo[a] = r_s1_q[a+AXES];
                n_s2_hi[a] = r_s1_q[a];
            end
        end
    end

    // Reduce to entry and exit
    always_comb begin
        n_s3_near = NEG_INF;
        n_s3_far  = POS_INF;
        for (int a = 0; a < AXES; a++) begin
            if (r_s2_lo[a] > n_s3_near) n_s3_near = r_s2_lo[a];
            if (r_s2_hi[a] < n_s3_far)  n_s3_far  = r_s2_hi[a];
        end
    end

    // Test the hit on exact values, then clamp
    always_comb begin
        n_s4_hit = (r_s3_far >= 0) && (r_s3_near <= r_s3_far);
        if (r_s3_near > SAT_HI)      n_s4_near = SAT_HI[COORD_W-1:0];
        else if (r_s3_near < SAT_LO) n_s4_near = SAT_LO[COORD_W-1:0];
        else                         n_s4_near = r_s3_near[COORD_W-1:0];
        if (r_s3_far > SAT_HI)       n_s4_far  = SAT_HI[COORD_W-1:0];
        else if (r_s3_far < SAT_LO)  n_s4_far  = SAT_LO[COORD_W-1:0];
        else                         n_s4_far  = r_s3_far[COORD_W-1:0];
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side  <= '0;
            r_s2_side  <= '0;
            r_s3_side  <= '0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_side  <= i_side;
            r_s2_side  <= r_s1_side;
            r_s3_side  <= r_s2_side;
            r_s4_valid <= r_s3_side.valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_q    <= n_s1_q;
            r_s2_lo   <= n_s2_lo;
            r_s2_hi   <= n_s2_hi;
            r_s3_near <= n_s3_near;
            r_s3_far  <= n_s3_far;
            r_s4_near <= n_s4_near;
            r_s4_far  <= n_s4_far;
            r_s4_hit  <= n_s4_hit;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_near  = r_s4_near;
    assign o_far   = r_s4_far;
    assign o_hit   = r_s4_hit;

endmodule

// ===== hdl/ray_box_slab_intersection.sv =====
// ============================================================================
// ray_box_slab_intersection
// Fixed-point ray versus axis-aligned box slab test, one pair per cycle.
// ============================================================================
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall   | origin, dir, box corners
//  out     | output    | o_out_valid / i_out_stall | near_dist, far_dist, hit
//
//  One beat enters per cycle unless in is stalled; each passes one prepare
//  stage, 49 divider stages (one quotient bit each) and four reduce stages.
//  Reset is synchronous, active low, and clears all valid bits.
//  The whole pipeline holds while the output beat is stalled; in is
//  stalled in exactly those cycles.
// ============================================================================
module ray_box_slab_intersection
    import rbs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [COORD_W-1:0] i_origin_x,
    input  logic signed [COORD_W-1:0] i_origin_y,
    input  logic signed [COORD_W-1:0] i_origin_z,
    input  logic signed [COORD_W-1:0] i_dir_x,
    input  logic signed [COORD_W-1:0] i_dir_y,
    input  logic signed [COORD_W-1:0] i_dir_z,
    input  logic signed [COORD_W-1:0] i_box_low_x,
    input  logic signed [COORD_W-1:0] i_box_low_y,
    input  logic signed [COORD_W-1:0] i_box_low_z,
    input  logic signed [COORD_W-1:0] i_box_high_x,
    input  logic signed [COORD_W-1:0] i_box_high_y,
    input  logic signed [COORD_W-1:0] i_box_high_z,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [COORD_W-1:0] o_near_dist,
    output logic signed [COORD_W-1:0] o_far_dist,
    output logic                      o_hit
);

    logic en;
    logic signed [COORD_W-1:0] org [AXES];
    logic signed [COORD_W-1:0] dir [AXES];
    logic signed [COORD_W-1:0] crn [LANES];

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [NUM_W-1:0]         n_num [LANES];
    logic [DEN_W-1:0]         n_den [LANES];
    logic [LANES-1:0]         n_neg;
    t_side                    n_side;

    logic [NUM_W-1:0] r_num [LANES];
    logic [DEN_W-1:0] r_den [LANES];
    logic [LANES-1:0] r_neg;
    t_side            r_p_side;
    t_side            r_side [DIV_STAGES];

    logic [LANES-1:0][NUM_W-1:0] quo;
    logic [LANES-1:0]            quo_neg;
    logic                        out_valid;
    logic [COORD_W-1:0]          out_near, out_far;

    // Hold everything while the output beat waits
    assign en         = !(out_valid && i_out_stall);
    assign o_in_stall = !en;

    assign org = '{i_origin_x, i_origin_y, i_origin_z};
    assign dir = '{i_dir_x, i_dir_y, i_dir_z};
    assign crn = '{i_box_low_x, i_box_low_y, i_box_low_z,
                   i_box_high_x, i_box_high_y, i_box_high_z};

    // Prepare divider operands as magnitudes and a sign
    always_comb begin
        diff = '0;
        mag  = '0;
        for (int k = 0; k < LANES; k++) begin
            diff     = DIFF_W'(crn[k]) - DIFF_W'(org[k % AXES]);
            mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            n_num[k] = {mag, {FRAC_W{1'b0}}};
            n_den[k] = dir[k % AXES][COORD_W-1] ? DEN_W'(-dir[k % AXES])
                                                : DEN_W'(dir[k % AXES]);
            n_neg[k] = diff[DIFF_W-1] ^ dir[k % AXES][COORD_W-1];
        end
        n_side.valid = i_in_valid;
        for (int a = 0; a < AXES; a++) begin
            n_side.zero[a]    = (dir[a] == '0);
            n_side.in_slab[a] = (crn[a] <= org[a]) && (org[a] <= crn[a+AXES]);
        end
    end

    // Register the prepare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_side <= '0;
        end else if (en) begin
            r_p_side <= n_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= n_num;
            r_den <= n_den;
            r_neg <= n_neg;
        end
    end

    // Carry valid and slab flags beside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) r_side[s] <= '0;
        end else if (en) begin
            r_side[0] <= r_p_side;
            for (int s = 1; s < DIV_STAGES; s++) r_side[s] <= r_side[s-1];
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        rbs_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num[k]),
            .i_den (r_den[k]),
            .i_neg (r_neg[k]),
            .o_quo (quo[k]),
            .o_neg (quo_neg[k])
        );
    end

    rbs_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_side[DIV_STAGES-1]),
        .i_quo   (quo),
        .i_neg   (quo_neg),
        .o_valid (out_valid),
        .o_near  (out_near),
        .o_far   (out_far),
        .o_hit   (o_hit)
    );

    assign o_out_valid = out_valid;
    assign o_near_dist = out_near;
    assign o_far_dist  = out_far;

endmodule

// ===== hdl/rbs_checker.sv =====
// ============================================================================
// rbs_checker
// Port-level checks on the slab test pipeline, bound to the top level.
// ============================================================================
module rbs_checker
    import rbs_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [COORD_W-1:0] o_near_dist,
    input logic signed [COORD_W-1:0] o_far_dist,
    input logic                      o_hit
);

    // A stalled output beat stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_near_dist) && $stable(o_far_dist)
            && $stable(o_hit))
        else $error("output beat changed under stall");

    // Input is only stalled by a stalled output beat
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // A hit exits at or beyond the origin
    a_hit_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_far_dist >= 0)
        else $error("hit with negative exit");

    // A hit enters no later than it exits
    a_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_near_dist <= o_far_dist)
        else $error("hit with entry beyond exit");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind ray_box_slab_intersection rbs_checker u_rbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_near_dist (o_near_dist),
    .o_far_dist  (o_far_dist),
    .o_hit       (o_hit)
);
